>>> rtl/mwr_pkg.sv
// Shared constants, types and helpers for the MIDI wire recorder.
package mwr_pkg;

   localparam int unsigned RingDepth = 128;
   localparam int unsigned RingAw    = $clog2(RingDepth);

   localparam logic [27:0] DeltaCap   = 28'h0FFFFFFF;
   localparam logic [31:0] TickReset  = 32'd1041667;
   localparam logic [7:0]  StSysexOn  = 8'hF0;
   localparam logic [7:0]  StSysexEnd = 8'hF7;
   localparam logic [7:0]  StRealTime = 8'hF8;
   localparam logic [7:0]  StStatus   = 8'h80;
   localparam logic [7:0]  DataMask   = 8'h7F;

   localparam logic [1:0] RegTickPeriod = 2'd0;
   localparam logic [1:0] RegEpoch      = 2'd1;
   localparam logic [1:0] RegCableSel   = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic rd_mem;     // pop one byte at the read pointer
      logic put_f7;     // close an open ring sysex
      logic put_bare;   // store the held byte without delta
      logic div_start;  // launch the tick divide
      logic delta_calc; // register the capped delta
      logic commit;     // advance recorded ticks, clear byte index
      logic put_seq;    // store one prefix or message byte
      logic load_out;   // move the result into the output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_read;
      logic do_close;
      logic do_bare;
      logic do_event;
      logic ring_sx;
      logic ev_rt;
      logic div_busy;
      logic fits;
      logic seq_last;
      logic out_free;
   } sts_type;

   function automatic logic [1:0] data_len(input logic [7:0] s);
      logic [1:0] n;
      n = 2'd0;
      case (s[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
         4'hC, 4'hD:                   n = 2'd1;
         4'hF: begin
            if (s == 8'hF1 || s == 8'hF3) n = 2'd1;
            else if (s == 8'hF2)          n = 2'd2;
         end
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] vlq_len(input logic [27:0] v);
      logic [2:0] n;
      if (v < 28'h80)          n = 3'd1;
      else if (v < 28'h4000)   n = 3'd2;
      else if (v < 28'h200000) n = 3'd3;
      else                     n = 3'd4;
      return n;
   endfunction

endpackage

>>> rtl/mwr_div.sv
// Bit-serial 64 by 32 unsigned divider, one quotient bit per cycle.
module mwr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;
   logic        ge;

   assign trial = {rem_ff, q_ff[63]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = 7'd0;
         busy_in = 1'b1;
         rem_in  = '0;
         q_in    = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         q_in   = {q_ff[62:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;
endmodule

>>> rtl/mwr_dp.sv
// Datapath: parser state, config registers, byte ring, tick math, output register.
module mwr_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                capture,
   input  logic                req_command,
   input  logic [7:0]          req_wire_byte,
   input  logic [3:0]          req_cable,
   input  logic [63:0]         req_time_ns,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  logic                rsp_stall,
   input  mwr_pkg::cmd_type    cmd,
   output mwr_pkg::sts_type    sts,
   output logic                rsp_valid,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_read_valid,
   output logic [6:0]          rsp_bytes_stored
);
   import mwr_pkg::*;

   logic [7:0] ring [RingDepth];

   logic [31:0] tick_ff;
   logic [63:0] epoch_ff;
   logic [4:0]  csel_ff;

   logic [RingAw-1:0] wp_ff, rp_ff;
   logic [63:0] rec_ff;
   logic [7:0]  rs_ff, rs_in;
   logic [7:0]  mb_ff [3];
   logic [7:0]  mb_in [3];
   logic [1:0]  ml_ff, ml_in;
   logic [1:0]  dbn_ff, dbn_in;
   logic        wsx_ff, wsx_in;
   logic        rsx_ff;

   logic        isrd_ff, close_ff, bare_ff, event_ff;
   logic        close_in, bare_in, event_in;
   logic [7:0]  ev_ff [3];
   logic [7:0]  ev_in [3];
   logic [1:0]  evl_ff, evl_in;
   logic [63:0] time_ff;

   logic [7:0]  rdd_ff;
   logic        rdv_ff;
   logic [27:0] delta_ff;
   logic [2:0]  k_ff;

   logic        ov_ff;
   logic [7:0]  od_ff;
   logic        ovd_ff;
   logic [6:0]  ob_ff;

   logic [RingAw-1:0] count, free;
   logic [63:0] dividend, quotient, diff;
   logic [31:0] divisor;
   logic        div_busy;
   logic [2:0]  vl;
   logic [3:0]  need;
   logic        cable_ok;
   logic        wr_en;
   logic [7:0]  wr_data, seq_byte;
   logic [1:0]  shsel;
   logic [2:0]  midx;

   assign count = wp_ff - rp_ff;
   assign free  = RingAw'(RingDepth - 1) - count;
   assign cable_ok = csel_ff[4] || (csel_ff[3:0] == req_cable);

   // wire parser: mirrors running status assembly
   always_comb begin
      rs_in    = rs_ff;
      mb_in    = mb_ff;
      ml_in    = ml_ff;
      dbn_in   = dbn_ff;
      wsx_in   = wsx_ff;
      close_in = 1'b0;
      bare_in  = 1'b0;
      event_in = 1'b0;
      ev_in    = '{req_wire_byte, 8'h00, 8'h00};
      evl_in   = 2'd1;
      if (req_wire_byte >= StRealTime) begin
         event_in = 1'b1;
      end else if (req_wire_byte == StSysexEnd) begin
         if (wsx_ff) begin
            wsx_in   = 1'b0;
            close_in = 1'b1;
         end
      end else if (req_wire_byte == StSysexOn) begin
         wsx_in   = 1'b1;
         rs_in    = '0;
         ml_in    = '0;
         event_in = 1'b1;
      end else if (req_wire_byte >= StStatus) begin
         if (wsx_ff) begin
            wsx_in   = 1'b0;
            close_in = 1'b1;
         end
         if (req_wire_byte >= 8'hF1) rs_in = '0;
         else                        rs_in = req_wire_byte;
         if (req_wire_byte == 8'hF4 || req_wire_byte == 8'hF5) begin
            ml_in = '0;
         end else begin
            mb_in[0] = req_wire_byte;
            ml_in    = 2'd1;
            dbn_in   = data_len(req_wire_byte);
            if (dbn_in == 2'd0) begin
               event_in = 1'b1;
               ml_in    = '0;
            end
         end
      end else if (wsx_ff) begin
         bare_in = 1'b1;
      end else if (ml_ff == 2'd0 && rs_ff == 8'd0) begin
         ml_in = ml_ff;
      end else begin
         if (ml_ff == 2'd0) begin
            mb_in[0] = rs_ff;
            ml_in    = 2'd1;
            dbn_in   = data_len(rs_ff);
         end
         if (ml_in == 2'd3 || dbn_in == 2'd0) begin
            ml_in = '0;
         end else begin
            mb_in[ml_in] = req_wire_byte;
            ml_in        = ml_in + 2'd1;
            dbn_in       = dbn_in - 2'd1;
            if (dbn_in == 2'd0) begin
               event_in = 1'b1;
               ev_in    = mb_in;
               evl_in   = ml_in;
               ml_in    = '0;
            end
         end
      end
   end

   // tick divide
   assign dividend = (time_ff < epoch_ff) ? 64'd0 : time_ff - epoch_ff;
   assign divisor  = (tick_ff == 32'd0) ? 32'd1 : tick_ff;

   mwr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign diff = quotient - rec_ff;

   // delta prefix and message byte sequence
   assign vl   = vlq_len(delta_ff);
   assign need = 4'(vl) + 4'(evl_ff) + ((ev_ff[0] == StSysexOn) ? 4'd1 : 4'd0);
   assign shsel = 2'(vl - 3'd1 - k_ff);
   assign midx  = k_ff - vl;

   always_comb begin
      if (k_ff < vl) begin
         case (shsel)
            2'd0:    seq_byte = {1'b0, delta_ff[6:0]};
            2'd1:    seq_byte = {1'b1, delta_ff[13:7]};
            2'd2:    seq_byte = {1'b1, delta_ff[20:14]};
            2'd3:    seq_byte = {1'b1, delta_ff[27:21]};
            default: seq_byte = '0;
         endcase
      end else begin
         seq_byte = ev_ff[midx[1:0]];
      end
   end

   // single ring write port
   always_comb begin
      wr_en   = 1'b0;
      wr_data = seq_byte;
      if (cmd.put_f7 && rsx_ff) begin
         wr_en   = 1'b1;
         wr_data = StSysexEnd;
      end else if (cmd.put_bare && rsx_ff && free > RingAw'(1)) begin
         wr_en   = 1'b1;
         wr_data = ev_ff[0];
      end else if (cmd.put_seq) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) ring[wp_ff] <= wr_data;
      if (cmd.rd_mem) rdd_ff <= ring[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= TickReset;
         epoch_ff <= '0;
         csel_ff  <= 5'h1F;
         wp_ff    <= '0;
         rp_ff    <= '0;
         rec_ff   <= '0;
         rs_ff    <= '0;
         mb_ff    <= '{default: '0};
         ml_ff    <= '0;
         dbn_ff   <= '0;
         wsx_ff   <= 1'b0;
         rsx_ff   <= 1'b0;
         isrd_ff  <= 1'b0;
         close_ff <= 1'b0;
         bare_ff  <= 1'b0;
         event_ff <= 1'b0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               RegTickPeriod: tick_ff  <= csr_data[31:0];
               RegEpoch:      epoch_ff <= csr_data;
               RegCableSel:   csel_ff  <= csr_data[4:0];
               default:       ;
            endcase
         end
         if (capture) begin
            isrd_ff  <= req_command;
            close_ff <= 1'b0;
            bare_ff  <= 1'b0;
            event_ff <= 1'b0;
            rdv_ff   <= 1'b0;
            if (!req_command && cable_ok) begin
               rs_ff    <= rs_in;
               mb_ff    <= mb_in;
               ml_ff    <= ml_in;
               dbn_ff   <= dbn_in;
               wsx_ff   <= wsx_in;
               close_ff <= close_in;
               bare_ff  <= bare_in;
               event_ff <= event_in;
            end
         end
         if (cmd.rd_mem && rp_ff != wp_ff) begin
            rdv_ff <= 1'b1;
            rp_ff  <= rp_ff + RingAw'(1);
         end
         if (wr_en) wp_ff <= wp_ff + RingAw'(1);
         if (cmd.put_f7) rsx_ff <= 1'b0;
         if (cmd.commit) rec_ff <= rec_ff + 64'(delta_ff);
         if (cmd.put_seq && sts.seq_last && ev_ff[0] == StSysexOn) rsx_ff <= 1'b1;
         if (cmd.load_out) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         ev_ff   <= ev_in;
         evl_ff  <= evl_in;
         time_ff <= req_time_ns;
      end
      if (cmd.delta_calc) begin
         if (quotient > rec_ff) delta_ff <= (diff > 64'(DeltaCap)) ? DeltaCap : diff[27:0];
         else                   delta_ff <= '0;
      end
      if (cmd.commit) k_ff <= '0;
      else if (cmd.put_seq) k_ff <= k_ff + 3'd1;
      if (cmd.load_out) begin
         od_ff  <= rdv_ff ? rdd_ff : 8'd0;
         ovd_ff <= rdv_ff;
         ob_ff  <= 7'(count);
      end
   end

   always_comb begin
      sts.is_read  = isrd_ff;
      sts.do_close = close_ff;
      sts.do_bare  = bare_ff;
      sts.do_event = event_ff;
      sts.ring_sx  = rsx_ff;
      sts.ev_rt    = (evl_ff == 2'd1) && (ev_ff[0] >= StRealTime);
      sts.div_busy = div_busy;
      sts.fits     = free >= RingAw'(need);
      sts.seq_last = k_ff == (vl + 3'(evl_ff) - 3'd1);
      sts.out_free = !ov_ff || !rsp_stall;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_read_data    = od_ff;
   assign rsp_read_valid   = ovd_ff;
   assign rsp_bytes_stored = ob_ff;
endmodule

>>> rtl/mwr_ctrl.sv
// Controller: sequences reads, sysex closes, tick divide and ring writes.
module mwr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                capture,
   input  mwr_pkg::sts_type    sts,
   output mwr_pkg::cmd_type    cmd,
   output logic                busy
);
   import mwr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CLOSE, S_BARE, S_EVCHK, S_DIV, S_DELTA, S_CHECK, S_PUT, S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE:  if (capture) state_in = S_CLOSE;
         S_READ: begin
            state_in = S_FIN;
         end
         S_CLOSE: begin
            if (sts.is_read) begin
               cmd.rd_mem = 1'b1;
               state_in   = S_READ;
            end else begin
               cmd.put_f7 = sts.do_close;
               if (sts.do_bare)       state_in = S_BARE;
               else if (sts.do_event) state_in = S_EVCHK;
               else                   state_in = S_FIN;
            end
         end
         S_BARE: begin
            cmd.put_bare = 1'b1;
            state_in     = S_FIN;
         end
         S_EVCHK: begin
            if (sts.ring_sx && sts.ev_rt) begin
               state_in = S_BARE;
            end else begin
               cmd.put_f7    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: if (!sts.div_busy) begin
            cmd.delta_calc = 1'b1;
            state_in       = S_DELTA;
         end
         S_DELTA: state_in = S_CHECK;
         S_CHECK: begin
            if (sts.fits) begin
               cmd.commit = 1'b1;
               state_in   = S_PUT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_PUT: begin
            cmd.put_seq = 1'b1;
            if (sts.seq_last) state_in = S_FIN;
         end
         S_FIN: if (sts.out_free) begin
            cmd.load_out = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = state_ff != S_IDLE;
endmodule

>>> rtl/midi_wire_to_timed_event_recorder.sv
// Top level of the MIDI wire recorder: ports, controller and datapath.
// Flow from the accepting edge to the response word: a read pops the ring in S_CLOSE and
// passes S_READ to S_FIN; a push storing an event runs the bit-serial tick divide, then
// one ring write per prefix and message byte, or is dropped whole when it does not fit;
// other pushes write at most one ring byte. S_FIN waits while the response register stalls.
// Throughput: one word at a time; the next word can be taken in the cycle after the response
// register loads. Reset: synchronous, clears pointers, parser and config to defaults;
// ring contents are left undefined and need no clearing pass.
module midi_wire_to_timed_event_recorder (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_wire_byte,
   input  logic [3:0]  req_cable,
   input  logic [63:0] req_time_ns,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic [6:0]  rsp_bytes_stored,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import mwr_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    busy;
   logic    capture;

   // take a word only while the controller idles
   assign req_stall = busy;
   assign capture   = req_valid && !busy;
   // registers accept writes at any time
   assign csr_ready = 1'b1;

   mwr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .capture (capture),
      .sts     (sts),
      .cmd     (cmd),
      .busy    (busy)
   );

   mwr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .capture          (capture),
      .req_command      (req_command),
      .req_wire_byte    (req_wire_byte),
      .req_cable        (req_cable),
      .req_time_ns      (req_time_ns),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_bytes_stored (rsp_bytes_stored)
   );
endmodule
